>>> rtl/plc_edge_counter_bank_unit_assert.svh
// Assertion macros used by the checker file of the counter bank.
`ifndef PLC_EDGE_COUNTER_BANK_UNIT_ASSERT_SVH
`define PLC_EDGE_COUNTER_BANK_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define PLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("counter bank assertion failed");

// Checks that a condition never holds outside of reset.
`define PLC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `PLC_ASSERT(lbl, clk, rst_n, (!(cond)))

`endif

>>> rtl/plc_ecb_pkg.sv
// Package with the types and constants of the counter bank.
package plc_ecb_pkg;

  localparam int unsigned NumCountersDef = 256;
  localparam int unsigned IdW = 8;

  localparam logic signed [31:0] CntMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CntMin = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CmdUp     = 3'd0,
    CmdDown   = 3'd1,
    CmdUpDown = 3'd2,
    CmdSet    = 3'd3,
    CmdRead   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [IdW-1:0]    slot;
    logic              count_up;
    logic              count_down;
    logic              clear_request;
    logic              load_request;
    logic signed [31:0] preset;
    logic signed [31:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic              up_done;
    logic              down_done;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic              up_prev;
    logic              down_prev;
    logic              up_flag;
    logic              down_flag;
  } entry_t;

endpackage

>>> rtl/plc_edge_counter_bank_unit.sv
// Top level of the counter bank: one counter per entry, updated by commands.
//
// Usage: drive an input word on in_word_i and raise start; the word is taken
// at the rising edge where start is high and busy is low. busy stays low, so
// a new word can be taken in every cycle, one word per cycle sustained.
// Each word names a counter and a command and yields exactly one result word.
// The result appears on out_word_o with out_valid_o high for one cycle.
// The word and the counter memory read are registered first, then the
// update and the result, which drive out_word_o and out_valid_o.
// Words that follow each other on the same counter are forwarded, so each
// sees the state that the previous one left.
// The receiver cannot stall; every result must be taken in its cycle.
// Reset clears the pipeline and all entry valid bits at once, so every
// counter reads as zero count, zero flags and zero edge levels afterward.
// A counter id at or above NUM_COUNTERS changes nothing and returns zeros.
module plc_edge_counter_bank_unit
  import plc_ecb_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = NumCountersDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int unsigned AddrW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam logic [IdW:0] NumLim = (IdW + 1)'(NUM_COUNTERS);

  entry_t              mem_q [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] valid_q;

  logic                accept;
  logic                in_range_in;
  logic [AddrW-1:0]    addr_in;

  logic                s1_valid_q;
  in_word_t            s1_word_q;
  logic                s1_in_range_q;
  logic [AddrW-1:0]    s1_addr_q;
  entry_t              rd_q;
  logic                rd_valid_q;
  logic                fwd_hit_q, fwd_hit_d;
  entry_t              fwd_q;

  entry_t              cur, nxt;
  logic                wr_en;
  logic                up_edge, down_edge;
  logic signed [31:0]  inc_val, dec_val, up_val, dn_val, ud_val;

  logic                out_valid_q;
  out_word_t           out_word_q, out_word_d;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign in_range_in = {1'b0, in_word_i.slot} < NumLim;
  assign addr_in     = in_word_i.slot[AddrW-1:0];
  assign wr_en       = s1_valid_q && s1_in_range_q;
  assign fwd_hit_d   = wr_en && in_range_in && (addr_in == s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      s1_valid_q  <= accept;
      out_valid_q <= s1_valid_q;
      if (wr_en) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= nxt;
    end
    if (accept) begin
      rd_q <= mem_q[addr_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q     <= in_word_i;
      s1_in_range_q <= in_range_in;
      s1_addr_q     <= addr_in;
      rd_valid_q    <= valid_q[addr_in];
      fwd_hit_q     <= fwd_hit_d;
    end
    fwd_q      <= nxt;
    out_word_q <= out_word_d;
  end

  always_comb begin
    if (fwd_hit_q) begin
      cur = fwd_q;
    end else if (rd_valid_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end

    up_edge   = s1_word_q.count_up && !cur.up_prev;
    down_edge = s1_word_q.count_down && !cur.down_prev;
    inc_val   = (cur.count == CntMax) ? cur.count : cur.count + 32'sd1;
    dec_val   = (cur.count == CntMin) ? cur.count : cur.count - 32'sd1;
    up_val    = up_edge ? inc_val : cur.count;
    dn_val    = down_edge ? dec_val : cur.count;

    priority if (s1_word_q.clear_request) begin
      ud_val = '0;
    end else if (s1_word_q.load_request) begin
      ud_val = s1_word_q.preset;
    end else if (up_edge && !down_edge) begin
      ud_val = inc_val;
    end else if (down_edge && !up_edge) begin
      ud_val = dec_val;
    end else begin
      ud_val = cur.count;
    end

    nxt = cur;
    unique case (cmd_e'(s1_word_q.command))
      CmdUp: begin
        if (s1_word_q.clear_request) begin
          nxt.count   = '0;
          nxt.up_flag = 1'b0;
        end else begin
          nxt.count   = up_val;
          nxt.up_flag = $signed(up_val) >= $signed(s1_word_q.preset);
        end
        nxt.up_prev = s1_word_q.count_up;
      end
      CmdDown: begin
        if (s1_word_q.load_request) begin
          nxt.count     = s1_word_q.preset;
          nxt.down_flag = 1'b0;
        end else begin
          nxt.count     = dn_val;
          nxt.down_flag = $signed(dn_val) <= 32'sd0;
        end
        nxt.down_prev = s1_word_q.count_down;
      end
      CmdUpDown: begin
        nxt.count     = ud_val;
        nxt.up_flag   = $signed(ud_val) >= $signed(s1_word_q.preset);
        nxt.down_flag = $signed(ud_val) <= 32'sd0;
        nxt.up_prev   = s1_word_q.count_up;
        nxt.down_prev = s1_word_q.count_down;
      end
      CmdSet: begin
        nxt.count = s1_word_q.new_value;
      end
      CmdRead: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase

    if (s1_in_range_q) begin
      out_word_d.count     = nxt.count;
      out_word_d.up_done   = nxt.up_flag;
      out_word_d.down_done = nxt.down_flag;
    end else begin
      out_word_d = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/plc_ecb_chk.sv
// Port checker of the counter bank and its bind to the top level.
`include "plc_edge_counter_bank_unit_assert.svh"

module plc_ecb_chk
  import plc_ecb_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = NumCountersDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input out_word_t out_word_o
);

  localparam logic [IdW:0] NumLim = (IdW + 1)'(NUM_COUNTERS);

  logic accept;
  logic out_of_range;

  assign accept       = start && !busy;
  assign out_of_range = {1'b0, in_word_i.slot} >= NumLim;

  `PLC_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  `PLC_ASSERT(a_result_follows, clk_i, rst_ni, (accept |-> ##2 out_valid_o))
  `PLC_ASSERT(a_no_spurious, clk_i, rst_ni, (out_valid_o |-> $past(accept, 2)))
  `PLC_ASSERT(a_range_zero, clk_i, rst_ni, ((accept && out_of_range) |-> ##2 (out_word_o == '0)))

endmodule

bind plc_edge_counter_bank_unit plc_ecb_chk #(
  .NUM_COUNTERS(NUM_COUNTERS)
) u_plc_ecb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_word_o (out_word_o)
);
